// ===== sv/mer_pkg.sv =====
// ----------------------------------------------------------------------------
// mer_pkg - shared definitions for the midpoint ellipse rasterizer
// Operation codes of the input channel and the control word of the shared
// multiply-accumulate unit.
// ----------------------------------------------------------------------------
package mer_pkg;

  // Input operation codes
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Shared unit control: product or shifted linear term, add or subtract
  typedef struct packed {
    logic use_mul;
    logic neg;
  } mac_ctl_t;

endpackage

// ===== sv/mer_channels_if.sv =====
// ----------------------------------------------------------------------------
// mer_in_if / mer_out_if - valid/ready channels of the ellipse rasterizer
// Input channel carries the operation with centre and radii, output channel
// carries one pixel per transfer.
// ----------------------------------------------------------------------------
interface mer_in_if #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 12
);
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic signed [COORD_BITS-1:0]  center_x;
  logic signed [COORD_BITS-1:0]  center_y;
  logic        [RADIUS_BITS-1:0] radius_x;
  logic        [RADIUS_BITS-1:0] radius_y;

  modport source (output valid, operation, center_x, center_y, radius_x, radius_y,
                  input ready);
  modport sink   (input valid, operation, center_x, center_y, radius_x, radius_y,
                  output ready);
endinterface

interface mer_out_if #(
  parameter int COORD_BITS = 12
);
  logic                       valid;
  logic                       ready;
  logic signed [COORD_BITS:0] pixel_x;
  logic signed [COORD_BITS:0] pixel_y;
  logic                       last_of_step;
  logic                       ellipse_done;

  modport source (output valid, pixel_x, pixel_y, last_of_step, ellipse_done,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_of_step, ellipse_done,
                  output ready);
endinterface

// ===== sv/mer_mac.sv =====
// ----------------------------------------------------------------------------
// mer_mac - shared multiply-accumulate unit
// Adds to or subtracts from the accumulator input either a signed product or
// four times an unsigned linear term. The caller registers the result.
// ----------------------------------------------------------------------------
module mer_mac #(
  parameter int RADIUS_BITS = 10
) (
  input  mer_pkg::mac_ctl_t               ctl,
  input  logic signed [4*RADIUS_BITS+7:0] acc,
  input  logic signed [2*RADIUS_BITS:0]   mul_a,
  input  logic signed [RADIUS_BITS+3:0]   mul_b,
  input  logic        [3*RADIUS_BITS+1:0] lin,
  output logic signed [4*RADIUS_BITS+7:0] res
);
  import mer_pkg::*;

  localparam int DW  = 4*RADIUS_BITS + 8;
  localparam int SW  = 3*RADIUS_BITS + 2;
  localparam int PRW = 3*RADIUS_BITS + 5;

  logic signed [PRW-1:0] prod;
  logic signed [DW-1:0]  term;

  // product or shifted linear term
  assign prod = mul_a * mul_b;

  always_comb begin
    if (ctl.use_mul) begin
      term = DW'(prod);
    end else begin
      term = signed'({{(DW-SW-2){1'b0}}, lin, 2'b00});
    end
  end

  assign res = ctl.neg ? (acc - term) : (acc + term);

endmodule

// ===== sv/midpoint_ellipse_rasterizer_core.sv =====
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_core - midpoint ellipse rasterizer
// Steps an axis-aligned ellipse one point per advance and emits the four
// symmetric pixels of each point. Decisions are exact integers scaled by 4.
//
//   channel | dir | payload                                          | handshake
//   --------+-----+--------------------------------------------------+----------
//   in_ch   | in  | operation, center_x, center_y, radius_x, radius_y | valid/ready
//   out_ch  | out | pixel_x, pixel_y, last_of_step, ellipse_done      | valid/ready
//
// One item at a time: in_ch.ready is high only while the sequencer is idle.
// Advance: four pixels go out, then x and y are stepped, all of the decision
// arithmetic going one term a cycle through the shared multiply-accumulate unit.
// Start: set-up runs first (squares, slope and decision products), then as above.
// An output register holds the last pixel, so a new item is taken while it waits;
// a stall on the result side holds the emit state. Reset: synchronous, active low.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_core #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 12
) (
  input  logic      clk,
  input  logic      rst_n,
  mer_in_if.sink    in_ch,
  mer_out_if.source out_ch
);
  import mer_pkg::*;

  localparam int R   = RADIUS_BITS;
  localparam int C   = COORD_BITS;
  localparam int SQW = 2*R;
  localparam int SW  = 3*R + 2;
  localparam int DW  = 4*R + 8;
  localparam int MAW = 2*R + 1;
  localparam int MBW = R + 4;
  localparam int XW  = R + 1;
  localparam int EW  = ((C > R + 2) ? C : R + 2) + 1;

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_SQX   = 13'b0000000000010,
    ST_SQY   = 13'b0000000000100,
    ST_SLP   = 13'b0000000001000,
    ST_DINIT = 13'b0000000010000,
    ST_CHK   = 13'b0000000100000,
    ST_CHA   = 13'b0000001000000,
    ST_CHB   = 13'b0000010000000,
    ST_EMIT  = 13'b0000100000000,
    ST_ADV   = 13'b0001000000000,
    ST_USX   = 13'b0010000000000,
    ST_USY   = 13'b0100000000000,
    ST_USR   = 13'b1000000000000
  } state_t;

  // control state
  state_t     state_r, state_nxt;
  logic       active_r, active_nxt;
  logic       r2_r, r2_nxt;
  logic       setup_r, setup_nxt;
  logic       ys_r, ys_nxt;
  logic [1:0] k_r, k_nxt;
  logic       out_valid_r, out_valid_nxt;

  // datapath state
  logic signed [C-1:0]   cx_r, cx_nxt;
  logic signed [C-1:0]   cy_r, cy_nxt;
  logic        [R-1:0]   rx_r, rx_nxt;
  logic        [R-1:0]   ry_r, ry_nxt;
  logic        [SQW-1:0] rx2_r, rx2_nxt;
  logic        [SQW-1:0] ry2_r, ry2_nxt;
  logic        [XW-1:0]  x_r, x_nxt;
  logic        [R-1:0]   y_r, y_nxt;
  logic        [SW-1:0]  sx_r, sx_nxt;
  logic        [SW-1:0]  sy_r, sy_nxt;
  logic signed [DW-1:0]  d_r, d_nxt;
  logic signed [C:0]     px_r, px_nxt;
  logic signed [C:0]     py_r, py_nxt;
  logic                  last_r, last_nxt;
  logic                  done_r, done_nxt;

  // shared unit operands
  mac_ctl_t              mac_ctl;
  logic signed [DW-1:0]  mac_acc;
  logic signed [MAW-1:0] mac_a;
  logic signed [MBW-1:0] mac_b;
  logic        [SW-1:0]  mac_lin;
  logic signed [DW-1:0]  mac_res;

  // misc combinational
  logic                  in_xfer;
  logic                  out_load;
  logic                  d_neg;
  logic                  d_pos;
  logic        [SW-1:0]  two_rx2;
  logic        [SW-1:0]  two_ry2;
  logic signed [EW-1:0]  cx_e;
  logic signed [EW-1:0]  cy_e;
  logic signed [EW-1:0]  x_e;
  logic signed [EW-1:0]  y_e;
  logic signed [EW-1:0]  px_e;
  logic signed [EW-1:0]  py_e;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);
  assign d_neg    = d_r[DW-1];
  assign d_pos    = !d_r[DW-1] && (d_r != '0);
  assign two_rx2  = {{(SW-SQW-1){1'b0}}, rx2_r, 1'b0};
  assign two_ry2  = {{(SW-SQW-1){1'b0}}, ry2_r, 1'b0};

  // pixel of the current symmetric set; order (+x,+y) (-x,-y) (+x,-y) (-x,+y)
  assign cx_e = EW'(cx_r);
  assign cy_e = EW'(cy_r);
  assign x_e  = signed'(EW'(x_r));
  assign y_e  = signed'(EW'(y_r));
  assign px_e = k_r[0] ? (cx_e - x_e) : (cx_e + x_e);
  assign py_e = (k_r[0] ^ k_r[1]) ? (cy_e - y_e) : (cy_e + y_e);

  // shared unit operand selection
  always_comb begin
    mac_ctl = '{use_mul: 1'b1, neg: 1'b0};
    mac_acc = '0;
    mac_a   = signed'({{(MAW-R){1'b0}}, rx_r});
    mac_b   = signed'({{(MBW-R){1'b0}}, rx_r});
    mac_lin = sx_r;
    case (state_r)
      ST_SQY: begin
        mac_a = signed'({{(MAW-R){1'b0}}, ry_r});
        mac_b = signed'({{(MBW-R){1'b0}}, ry_r});
      end
      ST_SLP: begin
        mac_a = signed'({1'b0, rx2_r});
        mac_b = signed'({{(MBW-R){1'b0}}, ry_r});
      end
      ST_DINIT: begin
        // 4*ry^2 + rx^2*(1 - 4*ry)
        mac_acc = signed'({{(DW-SQW-2){1'b0}}, ry2_r, 2'b00});
        mac_a   = signed'({1'b0, rx2_r});
        mac_b   = MBW'(1) - signed'({2'b00, ry_r, 2'b00});
      end
      ST_CHA: begin
        // d - ry^2*(4x+3)
        mac_acc = d_r;
        mac_a   = signed'({1'b0, ry2_r});
        mac_b   = -signed'({1'b0, x_r, 2'b11});
      end
      ST_CHB: begin
        // d + rx^2*(3-4y)
        mac_acc = d_r;
        mac_a   = signed'({1'b0, rx2_r});
        mac_b   = MBW'(3) - signed'({2'b00, y_r, 2'b00});
      end
      ST_USX: begin
        mac_ctl = '{use_mul: 1'b0, neg: 1'b0};
        mac_acc = d_r;
        mac_lin = sx_r;
      end
      ST_USY: begin
        mac_ctl = '{use_mul: 1'b0, neg: 1'b1};
        mac_acc = d_r;
        mac_lin = sy_r;
      end
      ST_USR: begin
        mac_ctl = '{use_mul: 1'b0, neg: 1'b0};
        mac_acc = d_r;
        mac_lin = r2_r ? {{(SW-SQW){1'b0}}, rx2_r} : {{(SW-SQW){1'b0}}, ry2_r};
      end
      default: begin
        mac_ctl = '{use_mul: 1'b1, neg: 1'b0};
      end
    endcase
  end

  mer_mac #(
    .RADIUS_BITS(RADIUS_BITS)
  ) u_mer_mac (
    .ctl  (mac_ctl),
    .acc  (mac_acc),
    .mul_a(mac_a),
    .mul_b(mac_b),
    .lin  (mac_lin),
    .res  (mac_res)
  );

  // sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    r2_nxt        = r2_r;
    setup_nxt     = setup_r;
    ys_nxt        = ys_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    rx2_nxt       = rx2_r;
    ry2_nxt       = ry2_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    d_nxt         = d_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    last_nxt      = last_r;
    done_nxt      = done_r;

    // output register: drain on transfer, refill from the emit state
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      px_nxt        = px_e[C:0];
      py_nxt        = py_e[C:0];
      last_nxt      = (k_r == 2'd3);
      done_nxt      = (y_r == '0);
      k_nxt         = k_r + 2'd1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_ch.operation == OP_ADVANCE) begin
            if (active_r) begin
              state_nxt = ST_EMIT;
            end
          end else begin
            cx_nxt    = in_ch.center_x;
            cy_nxt    = in_ch.center_y;
            rx_nxt    = in_ch.radius_x;
            ry_nxt    = in_ch.radius_y;
            setup_nxt = 1'b1;
            state_nxt = ST_SQX;
          end
        end
      end
      ST_SQX: begin
        rx2_nxt   = mac_res[SQW-1:0];
        state_nxt = ST_SQY;
      end
      ST_SQY: begin
        ry2_nxt   = mac_res[SQW-1:0];
        state_nxt = ST_SLP;
      end
      ST_SLP: begin
        sy_nxt    = {mac_res[SW-2:0], 1'b0};
        sx_nxt    = '0;
        x_nxt     = '0;
        y_nxt     = ry_r;
        r2_nxt    = 1'b0;
        state_nxt = ST_DINIT;
      end
      ST_DINIT: begin
        d_nxt      = mac_res;
        active_nxt = 1'b1;
        state_nxt  = ST_CHK;
      end
      // region changeover once the slope reaches -1
      ST_CHK: begin
        if (!r2_r && !(sx_r < sy_r)) begin
          r2_nxt    = 1'b1;
          state_nxt = ST_CHA;
        end else begin
          state_nxt = setup_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_CHA: begin
        d_nxt     = mac_res;
        state_nxt = ST_CHB;
      end
      ST_CHB: begin
        d_nxt     = mac_res;
        state_nxt = setup_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_load && (k_r == 2'd3)) begin
          if (y_r == '0) begin
            active_nxt = 1'b0;
            state_nxt  = ST_IDLE;
          end else begin
            state_nxt = ST_ADV;
          end
        end
      end
      // step x and y, decide which decision terms follow
      ST_ADV: begin
        setup_nxt = 1'b0;
        if (!r2_r) begin
          x_nxt  = x_r + XW'(1);
          sx_nxt = sx_r + two_ry2;
          if (d_neg) begin
            ys_nxt = 1'b0;
          end else begin
            y_nxt  = y_r - R'(1);
            sy_nxt = sy_r - two_rx2;
            ys_nxt = 1'b1;
          end
          state_nxt = ST_USX;
        end else begin
          y_nxt  = y_r - R'(1);
          sy_nxt = sy_r - two_rx2;
          ys_nxt = 1'b1;
          if (d_pos) begin
            state_nxt = ST_USY;
          end else begin
            x_nxt     = x_r + XW'(1);
            sx_nxt    = sx_r + two_ry2;
            state_nxt = ST_USX;
          end
        end
      end
      ST_USX: begin
        d_nxt     = mac_res;
        state_nxt = ys_r ? ST_USY : ST_USR;
      end
      ST_USY: begin
        d_nxt     = mac_res;
        state_nxt = ST_USR;
      end
      ST_USR: begin
        d_nxt     = mac_res;
        state_nxt = r2_r ? ST_IDLE : ST_CHK;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= 1'b0;
      r2_r        <= 1'b0;
      setup_r     <= 1'b0;
      ys_r        <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      r2_r        <= r2_nxt;
      setup_r     <= setup_nxt;
      ys_r        <= ys_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    rx_r   <= rx_nxt;
    ry_r   <= ry_nxt;
    rx2_r  <= rx2_nxt;
    ry2_r  <= ry2_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    sx_r   <= sx_nxt;
    sy_r   <= sy_nxt;
    d_r    <= d_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    last_r <= last_nxt;
    done_r <= done_nxt;
  end

  // ports
  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_x      = px_r;
  assign out_ch.pixel_y      = py_r;
  assign out_ch.last_of_step = last_r;
  assign out_ch.ellipse_done = done_r;

endmodule

// ===== sv/mer_checker.sv =====
// ----------------------------------------------------------------------------
// mer_checker - port-level assertions for the ellipse rasterizer
// Watches both channels of the top level; attached by the bind below.
// ----------------------------------------------------------------------------
module mer_checker #(
  parameter int COORD_BITS = 12
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_operation,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [COORD_BITS:0] out_pixel_x,
  input logic signed [COORD_BITS:0] out_pixel_y,
  input logic                       out_last_of_step,
  input logic                       out_ellipse_done
);
  import mer_pkg::*;

  // a stalled pixel holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_x) &&
      $stable(out_pixel_y) && $stable(out_last_of_step) && $stable(out_ellipse_done))
    else $error("stalled pixel changed");

  // a start always occupies the sequencer
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == OP_START) |=> !in_ready)
    else $error("ready right after a start transfer");

  // no new item while a pixel set is still being emitted
  a_set_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_step |-> !in_ready)
    else $error("ready in the middle of a pixel set");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("pixel valid after reset");

endmodule

bind midpoint_ellipse_rasterizer_core mer_checker #(
  .COORD_BITS(COORD_BITS)
) u_mer_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_operation    (in_ch.operation),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_pixel_x     (out_ch.pixel_x),
  .out_pixel_y     (out_ch.pixel_y),
  .out_last_of_step(out_ch.last_of_step),
  .out_ellipse_done(out_ch.ellipse_done)
);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - self-checking bench for midpoint_ellipse_rasterizer_core
// Drives start and advance commands on the input channel. A built-in
// predictor steps the ellipse alongside the core and queues the pixels it
// expects. Every pixel transfer on the output channel is checked against the
// oldest queued pixel, field by field. Both sides insert random gaps, and one
// test holds the output off long enough to back the core up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import mer_pkg::*;

  localparam int RADIUS_BITS  = 10;
  localparam int COORD_BITS   = 12;
  localparam int ITEM_TARGET  = 370;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 30;

  typedef struct packed {
    logic                          operation;
    logic signed [COORD_BITS-1:0]  center_x;
    logic signed [COORD_BITS-1:0]  center_y;
    logic        [RADIUS_BITS-1:0] radius_x;
    logic        [RADIUS_BITS-1:0] radius_y;
  } ellipse_cmd_t;

  typedef struct packed {
    logic signed [COORD_BITS:0] pixel_x;
    logic signed [COORD_BITS:0] pixel_y;
    logic                       last_of_step;
    logic                       ellipse_done;
  } pixel_t;

  logic clk;
  logic rst_n;

  mer_in_if  #(.RADIUS_BITS(RADIUS_BITS), .COORD_BITS(COORD_BITS)) in_ch ();
  mer_out_if #(.COORD_BITS(COORD_BITS))                            out_ch ();

  midpoint_ellipse_rasterizer_core #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: exact integers, wide enough for every decision term
  longint ctr_col, ctr_row;
  longint rx_sq, ry_sq;
  longint pt_x, pt_y;
  longint slope_x, slope_y;
  longint decision;
  bit     region_two;
  bit     ellipse_busy;

  pixel_t expected_pixels[$];

  // Run bookkeeping
  int     errors;
  int     pixels_checked;
  int     emitting_items;
  int     starts_sent;
  int     ellipses_finished;
  longint cycle_count;
  bit     steady;
  bit     draining;
  int     sink_stall;
  int     pressure_hold;

  // --------------------------------------------------------------------------
  // Clock, reset and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Gap lengths: mostly none or short, now and then long
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // switch to region two once the slope reaches -1; decision re-based there
  task automatic enter_region_two_if_due();
    if (!region_two && !(slope_x < slope_y)) begin
      region_two = 1'b1;
      decision   = decision - ry_sq * (4 * pt_x + 3) + rx_sq * (3 - 4 * pt_y);
    end
  endtask

  task automatic step_point();
    if (!region_two) begin
      pt_x++;
      slope_x += 2 * ry_sq;
      if (decision < 0) begin
        decision += 4 * (slope_x + ry_sq);
      end else begin
        pt_y--;
        slope_y  -= 2 * rx_sq;
        decision += 4 * (slope_x - slope_y + ry_sq);
      end
      enter_region_two_if_due();
    end else begin
      pt_y--;
      slope_y -= 2 * rx_sq;
      if (decision > 0) begin
        decision += 4 * (rx_sq - slope_y);
      end else begin
        pt_x++;
        slope_x  += 2 * ry_sq;
        decision += 4 * (slope_x - slope_y + rx_sq);
      end
    end
  endtask

  // four symmetric pixels: (+x,+y) (-x,-y) (+x,-y) (-x,+y)
  task automatic queue_point_set();
    longint xs[4];
    longint ys[4];
    pixel_t p;
    bit     done;
    done = (pt_y <= 0);
    xs[0] = ctr_col + pt_x;  ys[0] = ctr_row + pt_y;
    xs[1] = ctr_col - pt_x;  ys[1] = ctr_row - pt_y;
    xs[2] = ctr_col + pt_x;  ys[2] = ctr_row - pt_y;
    xs[3] = ctr_col - pt_x;  ys[3] = ctr_row + pt_y;
    for (int k = 0; k < 4; k++) begin
      p.pixel_x      = xs[k][COORD_BITS:0];
      p.pixel_y      = ys[k][COORD_BITS:0];
      p.last_of_step = (k == 3);
      p.ellipse_done = done;
      expected_pixels.push_back(p);
    end
    if (done) begin
      ellipse_busy = 1'b0;
      ellipses_finished++;
    end else begin
      step_point();
    end
  endtask

  // returns whether the command produces a pixel set
  task automatic predict_cmd(input ellipse_cmd_t c, output bit emits);
    longint rx;
    longint ry;
    emits = 1'b0;
    if (c.operation == OP_START) begin
      rx           = c.radius_x;
      ry           = c.radius_y;
      ctr_col      = $signed(c.center_x);
      ctr_row      = $signed(c.center_y);
      rx_sq        = rx * rx;
      ry_sq        = ry * ry;
      pt_x         = 0;
      pt_y         = ry;
      slope_x      = 0;
      slope_y      = 2 * rx_sq * ry;
      decision     = 4 * ry_sq - 4 * rx_sq * ry + rx_sq;
      region_two   = 1'b0;
      ellipse_busy = 1'b1;
      enter_region_two_if_due();
      queue_point_set();
      emits = 1'b1;
    end else if (ellipse_busy) begin
      queue_point_set();
      emits = 1'b1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Input side: one command per transfer
  // --------------------------------------------------------------------------
  // valid is left high after a transfer; the next call follows in the same step
  task automatic send_cmd(input ellipse_cmd_t c);
    int gap;
    bit emits;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= c.operation;
    in_ch.center_x  <= c.center_x;
    in_ch.center_y  <= c.center_y;
    in_ch.radius_x  <= c.radius_x;
    in_ch.radius_y  <= c.radius_y;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_cmd(c, emits);
    if (emits) emitting_items++;
    if (c.operation == OP_START) starts_sent++;
  endtask

  task automatic send_start(input int cx, input int cy, input int rx, input int ry);
    ellipse_cmd_t c;
    c.operation = OP_START;
    c.center_x  = cx[COORD_BITS-1:0];
    c.center_y  = cy[COORD_BITS-1:0];
    c.radius_x  = rx[RADIUS_BITS-1:0];
    c.radius_y  = ry[RADIUS_BITS-1:0];
    send_cmd(c);
  endtask

  // advance carries random junk in the fields it ignores
  task automatic send_advance();
    ellipse_cmd_t c;
    logic [63:0]  junk;
    junk        = {$urandom, $urandom};
    c           = junk[$bits(ellipse_cmd_t)-1:0];
    c.operation = OP_ADVANCE;
    send_cmd(c);
  endtask

  // start, then advance until the final set or the cap
  task automatic run_ellipse(input int cx, input int cy, input int rx, input int ry,
                             input int max_adv);
    int n;
    n = 0;
    send_start(cx, cy, rx, ry);
    while (ellipse_busy && n < max_adv) begin
      send_advance();
      n++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: random ready, one check per pixel transfer
  // --------------------------------------------------------------------------
  task automatic check_pixel();
    pixel_t want;
    if (expected_pixels.size() == 0) begin
      $error("unexpected pixel x=%0d y=%0d", out_ch.pixel_x, out_ch.pixel_y);
      errors++;
      return;
    end
    want = expected_pixels.pop_front();
    pixels_checked++;
    if (out_ch.pixel_x !== want.pixel_x) begin
      $error("pixel_x: expected %0d, got %0d", want.pixel_x, out_ch.pixel_x);
      errors++;
    end
    if (out_ch.pixel_y !== want.pixel_y) begin
      $error("pixel_y: expected %0d, got %0d", want.pixel_y, out_ch.pixel_y);
      errors++;
    end
    if (out_ch.last_of_step !== want.last_of_step) begin
      $error("last_of_step: expected %0b, got %0b", want.last_of_step,
             out_ch.last_of_step);
      errors++;
    end
    if (out_ch.ellipse_done !== want.ellipse_done) begin
      $error("ellipse_done: expected %0b, got %0b", want.ellipse_done,
             out_ch.ellipse_done);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) check_pixel();
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (pressure_hold > 0 && !draining) begin
      pressure_hold--;
      out_ch.ready <= 1'b0;
    end else if (sink_stall > 0 && !draining) begin
      sink_stall--;
      out_ch.ready <= 1'b0;
    end else if (steady || draining) begin
      out_ch.ready <= 1'b1;
    end else begin
      sink_stall = pick_gap();
      if (sink_stall > 0) begin
        sink_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // field extremes, degenerate radii, advance while idle, restart mid-ellipse
  task automatic test_directed_corners();
    send_advance();                                  // idle: no pixels
    run_ellipse(2047, -2048, 0, 0, 0);               // point ellipse, final at once
    send_advance();                                  // idle again after the final set
    run_ellipse(-2048, 2047, 0, 3, 10);              // zero radius_x: vertical line
    run_ellipse(100, -100, 5, 0, 0);                 // zero radius_y: one set only
    run_ellipse(-2048, -2048, 1023, 1023, 3);        // widest pixels, then dropped
    run_ellipse(2047, 2047, 1023, 1, 3);             // very flat, dropped as well
    run_ellipse(0, 0, 3, 2, 20);                     // small ellipse to completion
  endtask

  // output held off while the input keeps offering commands
  task automatic test_backpressure();
    steady        = 1'b1;
    pressure_hold = 200;
    run_ellipse($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                6, 4, 20);
    steady = 1'b0;
  endtask

  // mostly complete ellipses with random content, some noise and cut-offs
  task automatic test_random_ellipses();
    int r;
    int cx;
    int cy;
    int rx;
    int ry;
    while (emitting_items < ITEM_TARGET) begin
      r  = $urandom_range(0, 99);
      cx = $urandom_range(0, 4095) - 2048;
      cy = $urandom_range(0, 4095) - 2048;
      if (r < 65) begin
        rx = $urandom_range(0, 14);
        ry = $urandom_range(0, 14);
        run_ellipse(cx, cy, rx, ry, 100);
        if ($urandom_range(0, 9) == 0) send_advance();
      end else if (r < 77) begin
        rx = $urandom_range(0, 1);
        ry = $urandom_range(0, 25);
        if ($urandom_range(0, 1)) run_ellipse(cx, cy, rx, ry, 100);
        else run_ellipse(cx, cy, ry, rx, 100);
      end else if (r < 90) begin
        rx = $urandom_range(0, 1023);
        ry = $urandom_range(0, 1023);
        run_ellipse(cx, cy, rx, ry, $urandom_range(1, 8));
      end else begin
        // stray advances, then a sequence broken off early
        repeat ($urandom_range(1, 3)) begin
          if (!ellipse_busy) send_advance();
        end
        run_ellipse(cx, cy, $urandom_range(2, 14), $urandom_range(2, 14),
                    $urandom_range(0, 4));
      end
      // a run of items with no gaps on either side
      steady = ($urandom_range(0, 5) == 0);
    end
    steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_START;
    in_ch.center_x  = '0;
    in_ch.center_y  = '0;
    in_ch.radius_x  = '0;
    in_ch.radius_y  = '0;
    out_ch.ready    = 1'b0;
    ellipse_busy    = 1'b0;
    region_two      = 1'b0;
    steady          = 1'b0;
    draining        = 1'b0;
    sink_stall      = 0;
    pressure_hold   = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_corners();
    test_backpressure();
    test_random_ellipses();

    in_ch.valid <= 1'b0;
    draining    = 1'b1;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands that drew pixels, %0d of them starts; %0d ellipses ran",
             emitting_items, starts_sent, ellipses_finished);
    $display("to their final set and %0d pixels were checked in %0d cycles",
             pixels_checked, cycle_count);
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
